>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/pbr_pkg.sv
package pbr_pkg;

    localparam int COEF_COUNT = 6;
    localparam int FRAC_BITS  = 16;

    localparam int WORD_W    = 32;
    localparam int TOL_W     = 31;
    localparam int CAP_W     = 8;
    localparam int CIDX_W    = $clog2(COEF_COUNT);
    localparam int CFG_IDX_W = $clog2(COEF_COUNT + 2);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [TOL_W-1:0]         tol_t;
    typedef logic [CAP_W-1:0]         cap_t;
    typedef logic [CIDX_W-1:0]        cidx_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    // register indexes of the config port
    localparam cfg_idx_t REG_TOLERANCE = CFG_IDX_W'(COEF_COUNT);
    localparam cfg_idx_t REG_ITER_CAP  = CFG_IDX_W'(COEF_COUNT + 1);

    localparam cidx_t COEF_TOP   = CIDX_W'(COEF_COUNT - 1);
    localparam cidx_t COEF_START = CIDX_W'(COEF_COUNT - 2);

    localparam tol_t TOL_RESET = TOL_W'(33);
    // 0.0005 rounded to the fraction grid
    localparam tol_t TOL_ZERO_SUB = TOL_W'((5 * (1 << FRAC_BITS) + 5000) / 10000);
    localparam cap_t CAP_RESET = CAP_W'(64);
    localparam cap_t CAP_MIN   = CAP_W'(1);

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new interval, x = lower end
        logic mul;       // product = acc * x
        logic step;      // acc = sat(sat(product) + coef[k])
        logic take_fa;   // latch sign class of f(lower end)
        logic set_mid;   // x = midpoint, restart horner
        logic decide;    // move an end, count the pass
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_step; // horner index at the constant term
        logic stop;      // tolerance met or pass cap reached
    } stat_t;

endpackage

>>> rtl/core/pbr_ctrl.sv
module pbr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output pbr_pkg::cmd_t  cmd,
    input  pbr_pkg::stat_t stat
);
    import pbr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_MID    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       first_reg, first_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.step = 1'b1;
                if (!stat.last_step)
                    state_next = S_MUL;
                else if (first_reg)
                    state_next = S_MID;
                else
                    state_next = S_DECIDE;
            end
            S_MID:
            begin
                cmd.take_fa = first_reg;
                cmd.set_mid = 1'b1;
                first_next  = 1'b0;
                state_next  = S_MUL;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.stop)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MID;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_stop_done, clk, rst_n, state_reg == S_DECIDE && stat.stop, done && !busy)

endmodule

>>> rtl/core/pbr_datapath.sv
module pbr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  pbr_pkg::cfg_idx_t cfg_index,
    input  pbr_pkg::word_t    cfg_data,
    input  pbr_pkg::word_t    lower_end,
    input  pbr_pkg::word_t    upper_end,
    input  pbr_pkg::cmd_t     cmd,
    output pbr_pkg::stat_t    stat,
    output pbr_pkg::word_t    root,
    output pbr_pkg::word_t    value_at_root,
    output pbr_pkg::cap_t     passes,
    output logic              status
);
    import pbr_pkg::*;

    // config registers
    word_t coef_reg [COEF_COUNT];
    tol_t  tol_reg;
    cap_t  cap_reg;

    // search state
    word_t a_reg, b_reg, x_reg, acc_reg;
    logic signed [2*WORD_W-1:0] prod_reg;
    cidx_t k_reg;
    cap_t  n_reg;
    logic  fa_pos_reg;

    // result word
    word_t root_reg, value_reg;
    cap_t  passes_reg;
    logic  status_reg;

    logic signed [2*WORD_W-1:0] shifted;
    logic       fits;
    word_t      prod_sat;
    logic signed [WORD_W:0] sum_wide;
    word_t      acc_step;
    logic signed [WORD_W:0] ab_sum;
    word_t      mid;
    logic [WORD_W-1:0] mag;
    tol_t       tol_eff;
    cap_t       cap_eff;
    logic [CAP_W:0] n_inc;
    logic       in_tol;
    logic       at_cap;
    logic       same_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_COUNT; i++)
                coef_reg[i] <= '0;
            tol_reg <= TOL_RESET;
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index < CFG_IDX_W'(COEF_COUNT))
                coef_reg[cfg_index[CIDX_W-1:0]] <= cfg_data;
            else if (cfg_index == REG_TOLERANCE)
                tol_reg <= cfg_data[TOL_W-1:0];
            else if (cfg_index == REG_ITER_CAP)
                cap_reg <= cfg_data[CAP_W-1:0];
        end
    end

    // horner step: floor shift, saturate, add coefficient, saturate
    always_comb
    begin
        shifted  = prod_reg >>> FRAC_BITS;
        fits     = (&shifted[2*WORD_W-1:WORD_W-1]) || !(|shifted[2*WORD_W-1:WORD_W-1]);
        prod_sat = fits ? shifted[WORD_W-1:0] : (shifted[2*WORD_W-1] ? WORD_MIN : WORD_MAX);
        sum_wide = {prod_sat[WORD_W-1], prod_sat} + {coef_reg[k_reg][WORD_W-1], coef_reg[k_reg]};
        if (sum_wide[WORD_W] != sum_wide[WORD_W-1])
            acc_step = sum_wide[WORD_W] ? WORD_MIN : WORD_MAX;
        else
            acc_step = sum_wide[WORD_W-1:0];
    end

    // floor of the half sum
    assign ab_sum = {a_reg[WORD_W-1], a_reg} + {b_reg[WORD_W-1], b_reg};
    assign mid    = ab_sum[WORD_W:1];

    // stop test on f(mid)
    assign mag       = acc_reg[WORD_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign tol_eff   = (tol_reg == '0) ? TOL_ZERO_SUB : tol_reg;
    assign cap_eff   = (cap_reg == '0) ? CAP_MIN : cap_reg;
    assign n_inc     = {1'b0, n_reg} + 1'b1;
    assign in_tol    = (mag <= {1'b0, tol_eff});
    assign at_cap    = (n_inc >= {1'b0, cap_eff});
    assign same_side = (!acc_reg[WORD_W-1]) == fa_pos_reg;

    assign stat.last_step = (k_reg == '0);
    assign stat.stop      = in_tol || at_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_pos_reg <= 1'b0;
            n_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg <= '0;
                k_reg <= COEF_START;
            end
            else if (cmd.set_mid)
            begin
                k_reg <= COEF_START;
            end
            else if (cmd.step)
            begin
                k_reg <= k_reg - 1'b1;
            end
            if (cmd.take_fa)
                fa_pos_reg <= !acc_reg[WORD_W-1];
            if (cmd.decide)
                n_reg <= n_inc[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= lower_end;
            b_reg   <= upper_end;
            x_reg   <= lower_end;
            acc_reg <= coef_reg[COEF_TOP];
        end
        if (cmd.set_mid)
        begin
            x_reg   <= mid;
            acc_reg <= coef_reg[COEF_TOP];
        end
        if (cmd.mul)
            prod_reg <= acc_reg * x_reg;
        if (cmd.step)
            acc_reg <= acc_step;
        if (cmd.decide)
        begin
            if (same_side)
                a_reg <= x_reg;
            else
                b_reg <= x_reg;
            if (stat.stop)
            begin
                root_reg   <= x_reg;
                value_reg  <= acc_reg;
                passes_reg <= n_inc[CAP_W-1:0];
                status_reg <= !in_tol;
            end
        end
    end

    assign root          = root_reg;
    assign value_at_root = value_reg;
    assign passes        = passes_reg;
    assign status        = status_reg;

`include "assert_macros.svh"

    `ASSERT_SAME(a_pass_below_cap, clk, rst_n, cmd.decide, n_reg < cap_eff)
    `ASSERT_SAME(a_single_op, clk, rst_n, cmd.mul || cmd.step, !cmd.load && !cmd.decide)
    `ASSERT_NEXT(a_load_k, clk, rst_n, cmd.load, k_reg == COEF_START)

endmodule

>>> rtl/core/polynomial_bisection_root_unit.sv
// bisection root search on a degree-five polynomial, signed q16.16. pulse start with the
// interval ends while busy is low; the word is taken at that edge. exactly one result word
// follows, shown on root, value_at_root, passes and status for the single cycle that done
// is high; there is no back-pressure, so the receiver must capture it in that cycle. each
// evaluation runs horner's rule on one shared 32x32 multiplier, a multiply and then an
// accumulate per coefficient: f(lower end) is evaluated first, then each bisection pass
// runs midpoint, horner, compare and update; the default cap is 64 passes. busy drops in
// the done cycle and a new word may be taken right then. config writes are taken at any
// edge with cfg_we high but are meant only while busy is low.
module polynomial_bisection_root_unit (
    input  logic              clk,
    input  logic              rst_n,

    // config write port: coefficients 0..5, tolerance, iteration cap
    input  logic              cfg_we,
    input  pbr_pkg::cfg_idx_t cfg_index,
    input  pbr_pkg::word_t    cfg_data,

    // command side
    input  logic              start,
    output logic              busy,
    input  pbr_pkg::word_t    lower_end,
    input  pbr_pkg::word_t    upper_end,

    // result word, valid while done is high
    output logic              done,
    output pbr_pkg::word_t    root,
    output pbr_pkg::word_t    value_at_root,
    output pbr_pkg::cap_t     passes,
    output logic              status
);
    import pbr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: horner steps, midpoint, pass decision
    pbr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // config registers, interval ends, multiplier, accumulator and result word
    pbr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .lower_end     (lower_end),
        .upper_end     (upper_end),
        .cmd           (cmd),
        .stat          (stat),
        .root          (root),
        .value_at_root (value_at_root),
        .passes        (passes),
        .status        (status)
    );

endmodule

>>> dv/pbr_root_checker.sv
module pbr_root_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  pbr_pkg::cfg_idx_t cfg_index,
    input  pbr_pkg::word_t    cfg_data,
    input  logic              start,
    input  logic              busy,
    input  pbr_pkg::word_t    lower_end,
    input  pbr_pkg::word_t    upper_end,
    input  logic              done,
    input  pbr_pkg::word_t    root,
    input  pbr_pkg::word_t    value_at_root,
    input  pbr_pkg::cap_t     passes,
    input  logic              status,
    output int                mismatches,
    output int                outstanding
);
    import pbr_pkg::*;

    typedef struct {
        word_t root;
        word_t value;
        cap_t  passes;
        logic  status;
    } root_word_t;

    word_t      coef [COEF_COUNT];
    tol_t       tolerance;
    cap_t       iter_cap;
    root_word_t expected_roots [$];

    function automatic longint clamp_word(input longint v);
        if (v > longint'(WORD_MAX))
            return longint'(WORD_MAX);
        if (v < longint'(WORD_MIN))
            return longint'(WORD_MIN);
        return v;
    endfunction

    // horner's rule, each product floored and every step clamped
    function automatic longint eval_poly(input longint x);
        longint acc;
        acc = coef[COEF_COUNT-1];
        for (int k = COEF_COUNT - 2; k >= 0; k--)
        begin
            acc = clamp_word((acc * x) >>> FRAC_BITS);
            acc = clamp_word(acc + coef[k]);
        end
        return acc;
    endfunction

    function automatic root_word_t bisect(input longint lo, input longint hi);
        root_word_t r;
        longint     mid;
        longint     fmid;
        longint     mag;
        longint     tol;
        int         limit;
        int         count;
        bit         lo_nonneg;
        bit         finished;
        tol = tolerance;
        if (tol == 0)
            tol = (5 * (longint'(1) << FRAC_BITS) + 5000) / 10000;
        limit     = (iter_cap == 0) ? 1 : int'(iter_cap);
        lo_nonneg = eval_poly(lo) >= 0;
        count     = 0;
        finished  = 1'b0;
        mid       = 0;
        fmid      = 0;
        mag       = 0;
        while (!finished)
        begin
            mid  = (lo + hi) >>> 1;
            fmid = eval_poly(mid);
            if ((fmid >= 0) == lo_nonneg)
                lo = mid;
            else
                hi = mid;
            count++;
            mag      = (fmid < 0) ? -fmid : fmid;
            finished = (mag <= tol) || (count >= limit);
        end
        r.root   = word_t'(mid);
        r.value  = word_t'(fmid);
        r.passes = cap_t'(count);
        r.status = (mag > tol);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        root_word_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < COEF_COUNT; k++)
                coef[k] = '0;
            tolerance = TOL_RESET;
            iter_cap  = CAP_RESET;
            expected_roots.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("unexpected result word: root %0d", root);
                    mismatches++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (root !== want.root)
                    begin
                        $error("root: expected %0d, got %0d", want.root, root);
                        mismatches++;
                    end
                    if (value_at_root !== want.value)
                    begin
                        $error("value_at_root: expected %0d, got %0d", want.value,
                               value_at_root);
                        mismatches++;
                    end
                    if (passes !== want.passes)
                    begin
                        $error("passes: expected %0d, got %0d", want.passes, passes);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                end
            end
            // a word taken here sees the registers as they were before this edge
            if (start && !busy)
                expected_roots.push_back(bisect(lower_end, upper_end));
            if (cfg_we)
            begin
                if (cfg_index < COEF_COUNT)
                    coef[cfg_index] = cfg_data;
                else if (cfg_index == REG_TOLERANCE)
                    tolerance = cfg_data[TOL_W-1:0];
                else if (cfg_index == REG_ITER_CAP)
                    iter_cap = cfg_data[CAP_W-1:0];
            end
            outstanding = expected_roots.size();
        end
    end

endmodule

>>> dv/tb_polynomial_bisection_root_unit.sv
module tb_polynomial_bisection_root_unit;

    import pbr_pkg::*;

    localparam int     PERIOD        = 4;
    localparam int     RESET_CYCLES  = 5;
    localparam int     TOTAL_ITEMS   = 1150;
    // a stray done after the last word would show within a handful of cycles
    localparam int     SETTLE_CYCLES = 40;
    // every word at 255 passes plus the longest gaps,
    // taken four times over
    localparam longint RUN_LIMIT     = 64'd60_000_000;
    // 1.0 in q16.16
    localparam word_t  ONE           = word_t'(1 << FRAC_BITS);

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    word_t    cfg_data;
    logic     start;
    logic     busy;
    word_t    lower_end;
    word_t    upper_end;
    logic     done;
    word_t    root;
    word_t    value_at_root;
    cap_t     passes;
    logic     status;

    int mismatches;
    int outstanding;
    int items_sent;
    // when clear the sender never idles, so words go back to back
    bit burst_gaps;

    polynomial_bisection_root_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .lower_end     (lower_end),
        .upper_end     (upper_end),
        .done          (done),
        .root          (root),
        .value_at_root (value_at_root),
        .passes        (passes),
        .status        (status)
    );

    // predicts each result word from the register writes and the taken words
    pbr_root_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .lower_end     (lower_end),
        .upper_end     (upper_end),
        .done          (done),
        .root          (root),
        .value_at_root (value_at_root),
        .passes        (passes),
        .status        (status),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    // hang guard
    initial
    begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // one register write per cycle; cfg_we stays high across a batch
    task automatic write_reg(input cfg_idx_t idx, input word_t data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // present an interval and hold it until the block takes the word; start is
    // left high so that a following word in the same burst follows at once
    task automatic issue_interval(input word_t a, input word_t b);
        @(negedge clk);
        start     <= 1'b1;
        lower_end <= a;
        upper_end <= b;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // idle the sender; half the gaps begin only once the block is free, so the
    // gap lands around the done cycle rather than inside the search
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        if ($urandom_range(0, 1))
            while (busy)
                @(negedge clk);
        repeat (cycles) @(negedge clk);
    endtask

    // wait until every predicted word has come back and the block is idle
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    // coefficient of moderate size so that roots fall inside a few units
    function automatic word_t small_coef();
        logic [WORD_W-1:0] mag;
        mag = $urandom & ((32'd1 << $urandom_range(10, 19)) - 1);
        return $urandom_range(0, 1) ? word_t'(-mag) : word_t'(mag);
    endfunction

    // new register set for a random phase; returns the kind and size of phase
    task automatic program_random(output bit well_formed, output int count);
        int    r;
        int    degree;
        tol_t  tol;
        cap_t  cap;
        word_t d;
        well_formed = ($urandom_range(0, 9) < 7);
        degree      = $urandom_range(1, COEF_COUNT - 1);
        burst_gaps  = ($urandom_range(0, 3) != 0);
        // well-formed phases use a low-degree polynomial with modest terms;
        // the rest use full-scale coefficients that drive horner into saturation
        for (int k = 0; k < COEF_COUNT; k++)
        begin
            if (!well_formed)
                d = word_t'($urandom);
            else if (k > degree)
                d = '0;
            else
                d = small_coef();
            write_reg(cfg_idx_t'(k), d);
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            tol = '0;   // falls back to 0.0005
        else if (r < 20)
            tol = tol_t'($urandom);
        else if (r < 25)
            tol = '1;
        else
            tol = tol_t'($urandom_range(1, 4000));
        write_reg(REG_TOLERANCE, word_t'({1'($urandom_range(0, 1)), tol}));
        // long searches are kept to a few short phases
        r     = $urandom_range(0, 99);
        count = $urandom_range(20, 60);
        if (r < 3)
        begin
            cap   = '1;
            count = $urandom_range(4, 8);
        end
        else if (r < 8)
            cap = '0;   // one pass
        else if (r < 20)
            cap = CAP_RESET;
        else
            cap = cap_t'($urandom_range(1, 32));
        d            = word_t'($urandom);
        d[CAP_W-1:0] = cap;
        write_reg(REG_ITER_CAP, d);
        close_writes();
    endtask

    // send a phase worth of intervals in bursts of random length
    task automatic send_batch(input int count, input bit well_formed);
        int    burst_left;
        int    r;
        word_t a;
        word_t b;
        word_t swap;
        burst_left = $urandom_range(1, 8);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (!well_formed || r < 10)
            begin
                // noise: anywhere in the full range, either order
                a = word_t'($urandom);
                b = word_t'($urandom);
            end
            else
            begin
                // bracket around zero, where a sign change is likely
                a = word_t'($urandom_range(0, 8 << FRAC_BITS));
                a = -a;
                b = word_t'($urandom_range(0, 8 << FRAC_BITS));
                if (r < 20)
                begin
                    swap = a;
                    a    = b;
                    b    = swap;
                end
            end
            issue_interval(a, b);
            burst_left--;
            if (burst_left == 0)
            begin
                if (burst_gaps)
                    pause_sender($urandom_range(0, 30));
                burst_left = $urandom_range(1, 8);
            end
        end
    endtask

    initial
    begin
        bit well_formed;
        int count;

        // every input known from time zero
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        start      = 1'b0;
        lower_end  = '0;
        upper_end  = '0;
        items_sent = 0;
        burst_gaps = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults: f is zero everywhere, so the first pass converges;
        // full-scale ends, a reversed pair and a point interval
        issue_interval(WORD_MIN, WORD_MAX);
        issue_interval(WORD_MAX, WORD_MIN);
        issue_interval('0, '0);
        issue_interval(-1, -1);
        drain();

        // f(x) = x with two passes allowed: the root at zero is hit on the last
        // pass, also for the reversed interval; no sign change runs out the cap
        write_reg(cfg_idx_t'(1), ONE);
        write_reg(REG_ITER_CAP, word_t'(2));
        close_writes();
        issue_interval(-ONE, 3 * ONE);
        issue_interval(5 * ONE, 9 * ONE);
        issue_interval(3 * ONE, -ONE);
        drain();

        // a cap of zero gives one pass and a tolerance of zero means 0.0005;
        // the bits above each field are set and must be dropped
        write_reg(REG_ITER_CAP, word_t'(32'hFFFF_FF00));
        write_reg(REG_TOLERANCE, word_t'(32'h8000_0000));
        close_writes();
        issue_interval(-ONE, ONE);
        issue_interval(-ONE, ONE + 40);   // f(mid) just inside 0.0005
        issue_interval(-ONE, ONE + 70);   // f(mid) just outside
        issue_interval(-ONE, 5 * ONE);
        drain();

        // every coefficient on a rail, so horner steps can saturate; longest cap
        for (int k = 0; k < COEF_COUNT; k++)
            write_reg(cfg_idx_t'(k), (k % 2) ? WORD_MAX : WORD_MIN);
        write_reg(REG_TOLERANCE, word_t'(1));
        write_reg(REG_ITER_CAP, word_t'(255));
        close_writes();
        issue_interval(WORD_MIN, WORD_MAX);
        issue_interval(WORD_MAX, WORD_MIN);
        issue_interval(ONE, -ONE);
        drain();

        // widest tolerance: converged at once unless f sits on the negative rail
        write_reg(REG_TOLERANCE, word_t'(32'h7FFF_FFFF));
        close_writes();
        issue_interval(WORD_MIN, WORD_MIN);
        issue_interval('0, '0);
        issue_interval(WORD_MAX, WORD_MAX);
        drain();

        // random phases, each with a fresh register set written while idle
        while (items_sent < TOTAL_ITEMS)
        begin
            program_random(well_formed, count);
            send_batch(count, well_formed);
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
